// ===== design/bcf_pkg.sv =====
package bcf_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int MAX_SEGMENTS = 64;

    // segment_count field width and Q1.16 parameter width (t runs 0..1.0)
    localparam int SEG_W     = 7;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int STEP_W    = 4;

    localparam logic [STEP_W-1:0] LAST_STEP_QUAD  = STEP_W'(8);
    localparam logic [STEP_W-1:0] LAST_STEP_CUBIC = STEP_W'(13);

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] ctrl_a_x;
        logic signed [COORD_WIDTH-1:0] ctrl_a_y;
        logic signed [COORD_WIDTH-1:0] ctrl_b_x;
        logic signed [COORD_WIDTH-1:0] ctrl_b_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic        [SEG_W-1:0]       segment_count;
    } curve_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] from_x;
        logic signed [COORD_WIDTH-1:0] from_y;
        logic signed [COORD_WIDTH-1:0] to_x;
        logic signed [COORD_WIDTH-1:0] to_y;
        logic                          last_segment;
    } segment_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DIV,
        S_STEP,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } state_t;

    // multiplier operations; the product is written back in the following cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_UU,
        OP_TT,
        OP_W0Q,
        OP_W1Q,
        OP_W2Q,
        OP_W0C,
        OP_W1C,
        OP_W2C,
        OP_W3C,
        OP_MACX,
        OP_MACY
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
    } mac_cmd_t;

    typedef struct packed {
        logic     load;
        logic     step;
        mac_cmd_t mac;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic cubic;
        logic last;
    } dp_status_t;

    // per-point multiply schedule
    function automatic mac_cmd_t op_for(input logic cubic, input logic [STEP_W-1:0] step);
        mac_cmd_t          c;
        logic [STEP_W-1:0] d;
        c.op  = OP_NONE;
        c.idx = 2'd0;
        if (cubic)
        begin
            if (step == STEP_W'(0))
                c.op = OP_UU;
            else if (step == STEP_W'(1))
                c.op = OP_TT;
            else if (step == STEP_W'(2))
                c.op = OP_W0C;
            else if (step == STEP_W'(3))
                c.op = OP_W1C;
            else if (step == STEP_W'(4))
                c.op = OP_W2C;
            else if (step == STEP_W'(5))
                c.op = OP_W3C;
            else if (step <= STEP_W'(9))
            begin
                d     = step - STEP_W'(6);
                c.op  = OP_MACX;
                c.idx = d[1:0];
            end
            else if (step <= LAST_STEP_CUBIC)
            begin
                d     = step - STEP_W'(10);
                c.op  = OP_MACY;
                c.idx = d[1:0];
            end
        end
        else
        begin
            if (step == STEP_W'(0))
                c.op = OP_W0Q;
            else if (step == STEP_W'(1))
                c.op = OP_W1Q;
            else if (step == STEP_W'(2))
                c.op = OP_W2Q;
            else if (step <= STEP_W'(5))
            begin
                d     = step - STEP_W'(3);
                c.op  = OP_MACX;
                c.idx = d[1:0];
            end
            else if (step <= LAST_STEP_QUAD)
            begin
                d     = step - STEP_W'(6);
                c.op  = OP_MACY;
                c.idx = d[1:0];
            end
        end
        return c;
    endfunction

endpackage

// ===== design/bcf_div.sv =====
module bcf_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bcf_pkg::SEG_W-1:0] divisor,
    output logic [bcf_pkg::T_W-1:0]   quo,
    output logic [bcf_pkg::SEG_W-1:0] rem,
    output logic                     done
);
    import bcf_pkg::*;

    localparam int CNT_W = $clog2(T_W + 1);

    // restoring divide of 1.0 (Q1.16) by the segment count, one bit a cycle
    logic [T_W-1:0]   dvd_reg, dvd_next;
    logic [T_W-1:0]   quo_reg, quo_next;
    logic [SEG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [SEG_W:0]   trial;
    logic [SEG_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[T_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            dvd_next  = T_W'(1) << FRAC_BITS;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(T_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[T_W-2:0], 1'b0};
            quo_next = {quo_reg[T_W-2:0], ge};
            rem_next = ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== design/bcf_datapath.sv =====
module bcf_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bcf_pkg::dp_cmd_t          cmd,
    input  bcf_pkg::curve_t           curve,
    input  logic [bcf_pkg::T_W-1:0]   quo,
    input  logic [bcf_pkg::SEG_W-1:0] rem,
    output logic [bcf_pkg::SEG_W-1:0] divisor,
    output bcf_pkg::dp_status_t       status,
    output bcf_pkg::segment_t         seg
);
    import bcf_pkg::*;

    localparam int MB_W  = (COORD_WIDTH > T_W + 1) ? COORD_WIDTH : T_W + 1;
    localparam int P_W   = T_W + 1 + MB_W;
    localparam int ACC_W = P_W + 2;
    localparam int RND_W = ACC_W + 1 - FRAC_BITS;

    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [ACC_W:0]          HALF   = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    // curve registers
    logic                          cubic_reg;
    logic        [SEG_W-1:0]       n_reg;
    logic signed [COORD_WIDTH-1:0] coord_reg [0:7];
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;

    // parameter stepping: t += q0 (+1 on remainder wrap)
    logic [T_W-1:0]   t_reg;
    logic [SEG_W-1:0] r_reg;
    logic [SEG_W-1:0] i_reg;
    logic [T_W-1:0]   u;
    logic [T_W:0]     t_sum;
    logic [SEG_W:0]   r_sum;
    logic [SEG_W:0]   r_sub;
    logic             wrap;

    // weights and multiplier
    logic [T_W-1:0]          uu_reg, tt_reg;
    logic [T_W-1:0]          w_reg [0:3];
    logic [T_W-1:0]          a_val;
    logic [T_W-1:0]          b_w;
    logic signed [COORD_WIDTH-1:0] coord_sel;
    logic signed [MB_W-1:0]  mult_b;
    logic signed [P_W-1:0]   prod_next, prod_reg;
    op_t                     op_reg;
    logic [1:0]              idx_reg;
    logic [P_W+1:0]          p1, p2, scaled;
    logic [T_W-1:0]          wgt;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;

    // rounding
    logic [ACC_W:0]                sx, sy;
    logic signed [RND_W-1:0]       rx, ry;
    logic signed [COORD_WIDTH-1:0] nx, ny;
    segment_t                      seg_reg;
    logic [SEG_W-1:0]              n_eff;

    assign n_eff = (curve.segment_count == '0) ? SEG_W'(1) :
                   (curve.segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) :
                   curve.segment_count;

    assign u     = (T_W'(1) << FRAC_BITS) - t_reg;
    assign r_sum = {1'b0, r_reg} + {1'b0, rem};
    assign wrap  = r_sum >= {1'b0, n_reg};
    assign r_sub = r_sum - {1'b0, n_reg};
    assign t_sum = {1'b0, t_reg} + {1'b0, quo} + (T_W + 1)'(wrap);

    // operand selection
    always_comb
    begin
        a_val     = u;
        b_w       = u;
        coord_sel = coord_reg[{cmd.mac.op == OP_MACY, cmd.mac.idx}];
        unique case (cmd.mac.op)
            OP_UU, OP_W0Q: begin a_val = u;      b_w = u;      end
            OP_TT, OP_W2Q: begin a_val = t_reg;  b_w = t_reg;  end
            OP_W1Q:        begin a_val = u;      b_w = t_reg;  end
            OP_W0C:        begin a_val = uu_reg; b_w = u;      end
            OP_W1C:        begin a_val = uu_reg; b_w = t_reg;  end
            OP_W2C:        begin a_val = u;      b_w = tt_reg; end
            OP_W3C:        begin a_val = tt_reg; b_w = t_reg;  end
            OP_MACX, OP_MACY:
            begin
                a_val = w_reg[cmd.mac.idx];
                b_w   = u;
            end
            default:       begin a_val = u;      b_w = u;      end
        endcase
        if (cmd.mac.op == OP_MACX || cmd.mac.op == OP_MACY)
            mult_b = MB_W'(coord_sel);
        else
            mult_b = $signed(MB_W'(b_w));
        prod_next = $signed({1'b0, a_val}) * mult_b;
    end

    // write-back scaling: the 2ut and 3uut / 3utt terms
    assign p1 = {2'b00, prod_reg};
    assign p2 = {1'b0, prod_reg, 1'b0};
    always_comb
    begin
        unique case (op_reg)
            OP_W1Q:         scaled = p2;
            OP_W1C, OP_W2C: scaled = p1 + p2;
            default:        scaled = p1;
        endcase
    end
    assign wgt      = scaled[FRAC_BITS +: T_W];
    assign prod_ext = {{2{prod_reg[P_W-1]}}, prod_reg};

    // floor((sum + half) / 1.0), then clamp
    assign sx = {acc_x_reg[ACC_W-1], acc_x_reg} + HALF;
    assign sy = {acc_y_reg[ACC_W-1], acc_y_reg} + HALF;
    assign rx = $signed(sx[ACC_W:FRAC_BITS]);
    assign ry = $signed(sy[ACC_W:FRAC_BITS]);
    assign nx = (rx > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
                (rx < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(rx);
    assign ny = (ry > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
                (ry < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(ry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_NONE;
        else
            op_reg <= cmd.mac.op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        idx_reg  <= cmd.mac.idx;

        if (cmd.load)
        begin
            cubic_reg    <= curve.mode;
            n_reg        <= n_eff;
            coord_reg[0] <= curve.start_x;
            coord_reg[1] <= curve.ctrl_a_x;
            coord_reg[2] <= curve.mode ? curve.ctrl_b_x : curve.end_x;
            coord_reg[3] <= curve.end_x;
            coord_reg[4] <= curve.start_y;
            coord_reg[5] <= curve.ctrl_a_y;
            coord_reg[6] <= curve.mode ? curve.ctrl_b_y : curve.end_y;
            coord_reg[7] <= curve.end_y;
            prev_x_reg   <= curve.start_x;
            prev_y_reg   <= curve.start_y;
            t_reg        <= '0;
            r_reg        <= '0;
            i_reg        <= '0;
        end

        if (cmd.step)
        begin
            t_reg <= t_sum[T_W-1:0];
            r_reg <= wrap ? r_sub[SEG_W-1:0] : r_sum[SEG_W-1:0];
            i_reg <= i_reg + SEG_W'(1);
        end

        unique case (op_reg)
            OP_UU:                   uu_reg       <= wgt;
            OP_TT:                   tt_reg       <= wgt;
            OP_W0Q, OP_W0C:          w_reg[0]     <= wgt;
            OP_W1Q, OP_W1C:          w_reg[1]     <= wgt;
            OP_W2Q, OP_W2C:          w_reg[2]     <= wgt;
            OP_W3C:                  w_reg[3]     <= wgt;
            OP_MACX:
                acc_x_reg <= (idx_reg == 2'd0) ? prod_ext : acc_x_reg + prod_ext;
            OP_MACY:
                acc_y_reg <= (idx_reg == 2'd0) ? prod_ext : acc_y_reg + prod_ext;
            default:
            begin
            end
        endcase

        if (cmd.emit)
        begin
            seg_reg.from_x       <= prev_x_reg;
            seg_reg.from_y       <= prev_y_reg;
            seg_reg.to_x         <= nx;
            seg_reg.to_y         <= ny;
            seg_reg.last_segment <= status.last;
            prev_x_reg           <= nx;
            prev_y_reg           <= ny;
        end
    end

    assign divisor      = n_reg;
    assign status.cubic = cubic_reg;
    assign status.last  = (i_reg == n_reg);
    assign seg          = seg_reg;

endmodule

// ===== design/bcf_ctrl.sv =====
module bcf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                curve_valid,
    output logic                curve_ready,
    output logic                seg_valid,
    input  logic                seg_ready,
    output logic                div_start,
    input  logic                div_done,
    input  bcf_pkg::dp_status_t status,
    output bcf_pkg::dp_cmd_t    cmd
);
    import bcf_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [STEP_W-1:0] last_step;
    logic              slot_free;

    assign last_step = status.cubic ? LAST_STEP_CUBIC : LAST_STEP_QUAD;
    assign slot_free = !out_valid_reg || seg_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !seg_ready;
        curve_ready    = 1'b0;
        div_start      = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.mac.op     = OP_NONE;
        cmd.mac.idx    = 2'd0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                curve_ready = 1'b1;
                if (curve_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DSTART;
                end
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                step_next  = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.mac   = op_for(status.cubic, step_reg);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == last_step)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.last ? S_IDLE : S_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign seg_valid = out_valid_reg;

endmodule

// ===== design/bezier_curve_flattener_core.sv =====
// Channel   Dir  Handshake                 Payload
// curve     in   curve_valid/curve_ready   bcf_pkg::curve_t (one quadratic or cubic curve)
// seg       out  seg_valid/seg_ready       bcf_pkg::segment_t (one line segment)
//
// One curve transfer yields n segment transfers, n = segment_count clamped to 1..64.
// Per curve: load, divider start, then the divide (17 quotient bits, then done), then per
// segment one step, 14 (cubic) or 9 (quadratic) multiplier issues, a drain and an emit,
// all through the single shared 18 x 24 multiplier.
// Reset (rst_n, async low) clears the controller, divider count and multiplier op.
// curve_ready is high only when idle; a stalled seg holds its segment and holds back the
// next emit.
module bezier_curve_flattener_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              curve_valid,
    output logic              curve_ready,
    input  bcf_pkg::curve_t   curve,
    output logic              seg_valid,
    input  logic              seg_ready,
    output bcf_pkg::segment_t seg
);
    import bcf_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic             div_start;
    logic             div_done;
    logic [T_W-1:0]   div_quo;
    logic [SEG_W-1:0] div_rem;
    logic [SEG_W-1:0] divisor;

    // sequencer: load, divide, then step/issue/drain/emit per segment
    bcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .curve_valid (curve_valid),
        .curve_ready (curve_ready),
        .seg_valid   (seg_valid),
        .seg_ready   (seg_ready),
        .div_start   (div_start),
        .div_done    (div_done),
        .status      (status),
        .cmd         (cmd)
    );

    // q0 = floor(1.0 / n) and its remainder, reused by every t step of the curve
    bcf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (divisor),
        .quo     (div_quo),
        .rem     (div_rem),
        .done    (div_done)
    );

    // Bernstein weights, point accumulation, rounding, output register
    bcf_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .curve   (curve),
        .quo     (div_quo),
        .rem     (div_rem),
        .divisor (divisor),
        .status  (status),
        .seg     (seg)
    );

endmodule
